// ===== rtl/cmt_pkg.sv =====
package cmt_pkg;

	localparam int RES_W  = 61;
	localparam int WORD_W = 2 * RES_W;
	localparam int LG_W   = 3;

	localparam logic [RES_W-1:0] MP = 61'h1FFFFFFFFFFFFFFF;

	typedef logic [RES_W-1:0] res_t;

	// register indexes
	localparam logic REG_LOG_SIZE = 1'b0;
	localparam logic REG_INVERSE  = 1'b1;

	// write data select
	localparam logic [2:0] WS_IN    = 3'd0;
	localparam logic [2:0] WS_RDATA = 3'd1;
	localparam logic [2:0] WS_A     = 3'd2;
	localparam logic [2:0] WS_SUM   = 3'd3;
	localparam logic [2:0] WS_DIFF  = 3'd4;

	// multiplier operand pairs
	localparam logic [1:0] MSEL_RR = 2'd0;
	localparam logic [1:0] MSEL_II = 2'd1;
	localparam logic [1:0] MSEL_SS = 2'd2;

	typedef struct packed {
		logic            rd_en;
		logic            wr_en;
		logic [2:0]      wsel;
		logic            ld_a;
		logic            ld_b;
		logic            mul_start;
		logic [1:0]      mul_sel;
		logic            mul_tw;
		logic            t_ld;
		logic            cx_ld;
		logic            tw_init;
		logic            tw_upd;
		logic            out_ld;
		logic            out_last;
		logic            inv;
		logic [LG_W-1:0] tw_idx;
		logic [LG_W-1:0] lg;
	} cmt_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic out_free;
	} cmt_stat_t;

	function automatic res_t md_add(input res_t a, input res_t b);
		logic [RES_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MP}) begin
			s = s - {1'b0, MP};
		end
		return s[RES_W-1:0];
	endfunction

	// a + p - b wraps to a - b - 1 in 61 bits
	function automatic res_t md_sub(input res_t a, input res_t b);
		res_t d;
		d = a - b;
		if (a < b) begin
			d = d - res_t'(1);
		end
		return d;
	endfunction

	function automatic res_t tw_re(input logic [LG_W-1:0] s);
		res_t v;
		case (s)
			3'd0: v = 61'd2305843009213693950;
			3'd1: v = 61'd0;
			3'd2: v = 61'd1073741824;
			3'd3: v = 61'd612525257975972978;
			3'd4: v = 61'd83304533336094567;
			3'd5: v = 61'd1605717535313600273;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic res_t tw_im(input logic [LG_W-1:0] s);
		res_t v;
		case (s)
			3'd0: v = 61'd0;
			3'd1: v = 61'd1;
			3'd2: v = 61'd1073741824;
			3'd3: v = 61'd22027337052962166;
			3'd4: v = 61'd1608519025533736705;
			3'd5: v = 61'd477079714691672132;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/cmt_ram.sv =====
module cmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/cmt_mul.sv =====
module cmt_mul import cmt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  res_t a,
	input  res_t b,
	output res_t res,
	output logic done
);

	res_t               a_q, b_q;
	logic [WORD_W-1:0]  acc_q;
	logic [RES_W:0]     fold_q;
	logic               busy_q;
	logic [2:0]         step_q;
	logic [31:0]        op_a, op_b;
	logic [63:0]        pp;
	logic [6:0]         sh;
	logic [RES_W:0]     t;

	// partial products a0b0, a0b1, a1b0, a1b1, one per cycle
	assign op_a = step_q[1] ? {3'b0, a_q[60:32]} : a_q[31:0];
	assign op_b = step_q[0] ? {3'b0, b_q[60:32]} : b_q[31:0];
	assign pp   = op_a * op_b;
	assign sh   = ({6'b0, step_q[1]} + {6'b0, step_q[0]}) << 5;
	assign t    = {1'b0, fold_q[RES_W-1:0]} + {{RES_W{1'b0}}, fold_q[RES_W]};

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && step_q < 3'd4) begin
			acc_q <= acc_q + (WORD_W'(pp) << sh);
		end
		if (busy_q && step_q == 3'd4) begin
			fold_q <= {1'b0, acc_q[RES_W-1:0]} + {1'b0, acc_q[WORD_W-1:RES_W]};
		end
		if (busy_q && step_q == 3'd5) begin
			res <= (t >= {1'b0, MP}) ? 61'(t - {1'b0, MP}) : t[RES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/cmt_dp.sv =====
module cmt_dp import cmt_pkg::*; #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmt_cmd_t      cmd,
	input  logic [AW-1:0] addr,
	output cmt_stat_t     stat,
	input  res_t          elem_real,
	input  res_t          elem_imag,
	input  logic          out_ready,
	output logic          out_valid,
	output res_t          out_real,
	output res_t          out_imag,
	output logic          last_out
);

	logic [WORD_W-1:0] rdata, wdata;
	res_t rd_re, rd_im, in_re, in_im;
	res_t a_re_q, a_im_q, b_re_q, b_im_q, o_re_q, o_im_q, w_re_q, w_im_q;
	res_t t1_q, t2_q, t3_q, c_re_q, c_im_q;
	res_t y_re, y_im, ma, mb, mres;
	logic mdone;
	logic out_valid_q;

	function automatic res_t rotr(input res_t x, input logic [LG_W-1:0] k);
		logic [WORD_W-1:0] d;
		d = {x, x} >> k;
		return d[RES_W-1:0];
	endfunction

	assign rd_re = rdata[RES_W-1:0];
	assign rd_im = rdata[WORD_W-1:RES_W];
	assign in_re = (elem_real == MP) ? '0 : elem_real;
	assign in_im = (elem_imag == MP) ? '0 : elem_imag;

	always_comb begin
		case (cmd.wsel)
			WS_IN:    wdata = {in_im, in_re};
			WS_RDATA: wdata = rdata;
			WS_A:     wdata = {a_im_q, a_re_q};
			WS_SUM:   wdata = {md_add(a_im_q, c_im_q), md_add(a_re_q, c_re_q)};
			WS_DIFF:  wdata = {md_sub(a_im_q, c_im_q), md_sub(a_re_q, c_re_q)};
			default:  wdata = rdata;
		endcase
	end

	cmt_ram #(.WIDTH(WORD_W), .DEPTH(1 << AW)) u_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(addr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(addr),
		.rdata(rdata)
	);

	assign y_re = cmd.mul_tw ? w_re_q : b_re_q;
	assign y_im = cmd.mul_tw ? w_im_q : b_im_q;

	always_comb begin
		case (cmd.mul_sel)
			MSEL_RR: begin
				ma = o_re_q;
				mb = y_re;
			end
			MSEL_II: begin
				ma = o_im_q;
				mb = y_im;
			end
			default: begin
				ma = md_add(o_re_q, o_im_q);
				mb = md_add(y_re, y_im);
			end
		endcase
	end

	cmt_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (ma),
		.b     (mb),
		.res   (mres),
		.done  (mdone)
	);

	assign stat.mul_done = mdone;
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.ld_a) begin
			a_re_q <= rd_re;
			a_im_q <= rd_im;
		end
		if (cmd.ld_b) begin
			b_re_q <= rd_re;
			b_im_q <= rd_im;
		end
		if (cmd.t_ld) begin
			case (cmd.mul_sel)
				MSEL_RR: t1_q <= mres;
				MSEL_II: t2_q <= mres;
				default: t3_q <= mres;
			endcase
		end
		// three-multiply complex product
		if (cmd.cx_ld) begin
			c_re_q <= md_sub(t1_q, t2_q);
			c_im_q <= md_sub(md_sub(t3_q, t1_q), t2_q);
		end
		if (cmd.tw_init) begin
			o_re_q <= res_t'(1);
			o_im_q <= '0;
			w_re_q <= tw_re(cmd.tw_idx);
			w_im_q <= cmd.inv ? md_sub('0, tw_im(cmd.tw_idx)) : tw_im(cmd.tw_idx);
		end else if (cmd.tw_upd) begin
			o_re_q <= c_re_q;
			o_im_q <= c_im_q;
		end
		// scaling by 2^(61-lg) is a right rotation by lg
		if (cmd.out_ld) begin
			out_real <= cmd.inv ? rotr(rd_re, cmd.lg) : rd_re;
			out_imag <= cmd.inv ? rotr(rd_im, cmd.lg) : rd_im;
			last_out <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/cmt_ctrl.sv =====
module cmt_ctrl import cmt_pkg::*; #(
	parameter int MAX_LOG_POINTS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [LG_W-1:0]               cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cmt_stat_t                     stat,
	output cmt_cmd_t                      cmd,
	output logic [MAX_LOG_POINTS-1:0]     addr
);

	localparam int AW = MAX_LOG_POINTS;
	localparam int CW = AW + 1;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_SW_CHK = 5'd1;
	localparam logic [4:0] S_SW_RI  = 5'd2;
	localparam logic [4:0] S_SW_RR  = 5'd3;
	localparam logic [4:0] S_SW_WI  = 5'd4;
	localparam logic [4:0] S_SW_WR  = 5'd5;
	localparam logic [4:0] S_ST_INI = 5'd6;
	localparam logic [4:0] S_BF_RL  = 5'd7;
	localparam logic [4:0] S_BF_RH  = 5'd8;
	localparam logic [4:0] S_BF_LB  = 5'd9;
	localparam logic [4:0] S_MUL_GO = 5'd10;
	localparam logic [4:0] S_MUL_WT = 5'd11;
	localparam logic [4:0] S_CX     = 5'd12;
	localparam logic [4:0] S_BF_WL  = 5'd13;
	localparam logic [4:0] S_BF_WH  = 5'd14;
	localparam logic [4:0] S_BF_NXT = 5'd15;
	localparam logic [4:0] S_TW_UPD = 5'd16;
	localparam logic [4:0] S_EM_RD  = 5'd17;
	localparam logic [4:0] S_EM_LD  = 5'd18;

	logic [4:0]      state_q;
	logic [LG_W-1:0] log_size_q, lg_q, s_q, lg_eff;
	logic            inverse_q, twm_q;
	logic [CW-1:0]   cnt_q, i_q, k_q, cnt_inc, n_eff, n_q, half, span, lo_full, hi_full;
	logic [AW-1:0]   j_q, rev, r;
	logic [1:0]      mi_q;

	always_comb begin
		lg_eff = log_size_q;
		if (log_size_q == '0) begin
			lg_eff = 3'd1;
		end else if (log_size_q > LG_W'(MAX_LOG_POINTS)) begin
			lg_eff = LG_W'(MAX_LOG_POINTS);
		end
	end

	always_comb begin
		for (int b = 0; b < AW; b++) begin
			rev[b] = i_q[AW-1-b];
		end
	end

	assign r       = rev >> (LG_W'(AW) - lg_q);
	assign cnt_inc = cnt_q + CW'(1);
	assign n_eff   = CW'(1) << lg_eff;
	assign n_q     = CW'(1) << lg_q;
	assign half    = CW'(1) << s_q;
	assign span    = half << 1;
	assign lo_full = k_q + {1'b0, j_q};
	assign hi_full = lo_full + half;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.wsel    = WS_IN;
		cmd.mul_sel = mi_q;
		cmd.mul_tw  = twm_q;
		cmd.inv     = inverse_q;
		cmd.tw_idx  = s_q;
		cmd.lg      = lg_q;
		cmd.out_last = (i_q + CW'(1) == n_q);
		addr        = cnt_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				cmd.wr_en = in_valid;
			end
			S_SW_RI: begin
				cmd.rd_en = 1'b1;
				addr      = i_q[AW-1:0];
			end
			S_SW_RR: begin
				cmd.rd_en = 1'b1;
				cmd.ld_a  = 1'b1;
				addr      = r;
			end
			S_SW_WI: begin
				cmd.wr_en = 1'b1;
				cmd.wsel  = WS_RDATA;
				addr      = i_q[AW-1:0];
			end
			S_SW_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wsel  = WS_A;
				addr      = r;
			end
			S_ST_INI: begin
				cmd.tw_init = (s_q != lg_q);
			end
			S_BF_RL: begin
				cmd.rd_en = 1'b1;
				addr      = lo_full[AW-1:0];
			end
			S_BF_RH: begin
				cmd.rd_en = 1'b1;
				cmd.ld_a  = 1'b1;
				addr      = hi_full[AW-1:0];
			end
			S_BF_LB: begin
				cmd.ld_b = 1'b1;
			end
			S_MUL_GO: begin
				cmd.mul_start = 1'b1;
			end
			S_MUL_WT: begin
				cmd.t_ld = stat.mul_done;
			end
			S_CX: begin
				cmd.cx_ld = 1'b1;
			end
			S_BF_WL: begin
				cmd.wr_en = 1'b1;
				cmd.wsel  = WS_SUM;
				addr      = lo_full[AW-1:0];
			end
			S_BF_WH: begin
				cmd.wr_en = 1'b1;
				cmd.wsel  = WS_DIFF;
				addr      = hi_full[AW-1:0];
			end
			S_TW_UPD: begin
				cmd.tw_upd = 1'b1;
			end
			S_EM_RD: begin
				cmd.rd_en = 1'b1;
				addr      = i_q[AW-1:0];
			end
			S_EM_LD: begin
				cmd.out_ld = stat.out_free;
				addr       = i_q[AW-1:0];
			end
			default: begin
				cmd.wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			log_size_q <= 3'd6;
			inverse_q  <= 1'b0;
			lg_q       <= 3'd1;
			s_q        <= '0;
			twm_q      <= 1'b0;
			mi_q       <= '0;
			cnt_q      <= '0;
			i_q        <= '0;
			k_q        <= '0;
			j_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LOG_SIZE: log_size_q <= cfg_data;
					REG_INVERSE:  inverse_q  <= cfg_data[0];
					default:      inverse_q  <= inverse_q;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cnt_inc >= n_eff) begin
							cnt_q   <= '0;
							lg_q    <= lg_eff;
							i_q     <= '0;
							state_q <= S_SW_CHK;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
				end
				// bit-reversal permutation, one swap per pair
				S_SW_CHK: begin
					if (i_q == n_q) begin
						s_q     <= '0;
						state_q <= S_ST_INI;
					end else if (i_q < {1'b0, r}) begin
						state_q <= S_SW_RI;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_SW_RI: state_q <= S_SW_RR;
				S_SW_RR: state_q <= S_SW_WI;
				S_SW_WI: state_q <= S_SW_WR;
				S_SW_WR: begin
					i_q     <= i_q + CW'(1);
					state_q <= S_SW_CHK;
				end
				S_ST_INI: begin
					if (s_q == lg_q) begin
						i_q     <= '0;
						state_q <= S_EM_RD;
					end else begin
						j_q     <= '0;
						k_q     <= '0;
						state_q <= S_BF_RL;
					end
				end
				S_BF_RL: state_q <= S_BF_RH;
				S_BF_RH: state_q <= S_BF_LB;
				S_BF_LB: begin
					mi_q    <= MSEL_RR;
					twm_q   <= 1'b0;
					state_q <= S_MUL_GO;
				end
				S_MUL_GO: state_q <= S_MUL_WT;
				S_MUL_WT: begin
					if (stat.mul_done) begin
						if (mi_q == MSEL_SS) begin
							state_q <= S_CX;
						end else begin
							mi_q    <= mi_q + 2'd1;
							state_q <= S_MUL_GO;
						end
					end
				end
				S_CX: state_q <= twm_q ? S_TW_UPD : S_BF_WL;
				S_BF_WL: state_q <= S_BF_WH;
				S_BF_WH: state_q <= S_BF_NXT;
				S_BF_NXT: begin
					if (k_q + span < n_q) begin
						k_q     <= k_q + span;
						state_q <= S_BF_RL;
					end else begin
						k_q <= '0;
						if ({1'b0, j_q} + CW'(1) < half) begin
							// advance the twiddle power
							twm_q   <= 1'b1;
							mi_q    <= MSEL_RR;
							state_q <= S_MUL_GO;
						end else begin
							s_q     <= s_q + 3'd1;
							state_q <= S_ST_INI;
						end
					end
				end
				S_TW_UPD: begin
					j_q     <= j_q + AW'(1);
					state_q <= S_BF_RL;
				end
				S_EM_RD: state_q <= S_EM_LD;
				S_EM_LD: begin
					if (stat.out_free) begin
						if (cmd.out_last) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/complex_mersenne_transform.sv =====
// channel  | handshake             | payload
// cfg      | cfg_we                | cfg_index, cfg_data
// in       | in_valid / in_ready   | elem_real, elem_imag
// out      | out_valid / out_ready | out_real, out_imag, last_out
//
// loads are taken while idle; the load that fills N = 2^log_size entries (log_size
// 0 reads as 1, capped at MAX_LOG_POINTS) starts the transform: bit-reversal, then
// N/2*log_size butterflies, each three passes of the shared 32x32 multiplier plus
// memory access, with a twiddle step (N-1-log_size in all) between them, then
// each result is read from memory and loaded into the output register.
// reset is asynchronous, no clearing pass; output stalls hold the emit loop
module complex_mersenne_transform import cmt_pkg::*; #(
	parameter int MAX_LOG_POINTS = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [LG_W-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  res_t            elem_real,
	input  res_t            elem_imag,
	output logic            out_valid,
	input  logic            out_ready,
	output res_t            out_real,
	output res_t            out_imag,
	output logic            last_out
);

	cmt_cmd_t                  cmd;
	cmt_stat_t                 stat;
	logic [MAX_LOG_POINTS-1:0] addr;

	cmt_ctrl #(.MAX_LOG_POINTS(MAX_LOG_POINTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd),
		.addr     (addr)
	);

	cmt_dp #(.AW(MAX_LOG_POINTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.addr     (addr),
		.stat     (stat),
		.elem_real(elem_real),
		.elem_imag(elem_imag),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_real (out_real),
		.out_imag (out_imag),
		.last_out (last_out)
	);

endmodule

// ===== rtl/cmt_checker.sv =====
module cmt_checker import cmt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input res_t out_real,
	input res_t out_imag,
	input logic last_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_real) && $stable(out_imag)
			&& $stable(last_out))
		else $error("stalled result changed");

	// inputs are refused while a run is being emitted
	a_no_load_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |-> !in_ready)
		else $error("input ready during emit");

	// ready only drops after an input transfer
	a_fall_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("ready dropped without transfer");

	// ready returns together with the final result of a run
	a_rise_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid && last_out)
		else $error("ready returned without last result");

endmodule

bind complex_mersenne_transform cmt_checker u_cmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_real (out_real),
	.out_imag (out_imag),
	.last_out (last_out)
);

// ===== verif/cmt_checker.sv =====
module cmt_tb_checker import cmt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [LG_W-1:0] cfg_data,
	input  logic            in_valid,
	input  logic            in_ready,
	input  res_t            elem_real,
	input  res_t            elem_imag,
	input  logic            out_valid,
	input  logic            out_ready,
	input  res_t            out_real,
	input  res_t            out_imag,
	input  logic            last_out,
	output int              fail_count,
	output int              pending,
	output int              results_seen
);

	typedef struct {
		res_t re;
		res_t im;
		logic last;
	} spectrum_point_t;

	localparam res_t ROOT_RE [6] = '{61'd2305843009213693950, 61'd0, 61'd1073741824,
		61'd612525257975972978, 61'd83304533336094567, 61'd1605717535313600273};
	localparam res_t ROOT_IM [6] = '{61'd0, 61'd1, 61'd1073741824,
		61'd22027337052962166, 61'd1608519025533736705, 61'd477079714691672132};

	spectrum_point_t spectrum_q[$];
	res_t            slot_re [64];
	res_t            slot_im [64];
	logic [6:0]      fill_cnt;
	logic [LG_W-1:0] lg_reg;
	logic            inv_reg;

	assign pending = spectrum_q.size();

	function automatic res_t fold(input logic [62:0] v);
		logic [62:0] t;
		t = v[60:0] + v[62:61];
		t = t[60:0] + t[62:61];
		if (t >= {2'b0, MP}) begin
			t = t - {2'b0, MP};
		end
		return t[60:0];
	endfunction

	function automatic res_t p_add(input res_t a, input res_t b);
		return fold({2'b0, a} + {2'b0, b});
	endfunction

	function automatic res_t p_sub(input res_t a, input res_t b);
		return fold({2'b0, a} + {2'b0, MP} - {2'b0, b});
	endfunction

	function automatic res_t p_mul(input res_t a, input res_t b);
		logic [121:0] pr;
		pr = {61'b0, a} * {61'b0, b};
		return fold({2'b0, pr[60:0]} + {2'b0, pr[121:61]});
	endfunction

	function automatic void c_mul(input res_t ar, input res_t ai, input res_t br,
		input res_t bi, output res_t rr, output res_t ri);
		res_t t1, t2, t3;
		t1 = p_mul(ar, br);
		t2 = p_mul(ai, bi);
		t3 = p_mul(p_add(ar, ai), p_add(br, bi));
		rr = p_sub(t1, t2);
		ri = p_sub(p_sub(t3, t1), t2);
	endfunction

	function automatic void transform_slots(input int lg);
		int   n, r, half;
		res_t tmp, wr, wi, wpr, wpi, tr, ti, nr, ni;
		n = 1 << lg;
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int b = 0; b < lg; b++) begin
				r |= ((i >> b) & 1) << (lg - 1 - b);
			end
			if (i < r) begin
				tmp = slot_re[i]; slot_re[i] = slot_re[r]; slot_re[r] = tmp;
				tmp = slot_im[i]; slot_im[i] = slot_im[r]; slot_im[r] = tmp;
			end
		end
		for (int s = 0; s < lg; s++) begin
			half = 1 << s;
			wr = ROOT_RE[s];
			wi = inv_reg ? p_sub('0, ROOT_IM[s]) : ROOT_IM[s];
			wpr = 61'd1;
			wpi = '0;
			for (int j = 0; j < half; j++) begin
				for (int k = 0; k < n; k += 2 * half) begin
					c_mul(wpr, wpi, slot_re[k+j+half], slot_im[k+j+half], tr, ti);
					slot_re[k+j+half] = p_sub(slot_re[k+j], tr);
					slot_im[k+j+half] = p_sub(slot_im[k+j], ti);
					slot_re[k+j] = p_add(slot_re[k+j], tr);
					slot_im[k+j] = p_add(slot_im[k+j], ti);
				end
				c_mul(wpr, wpi, wr, wi, nr, ni);
				wpr = nr;
				wpi = ni;
			end
		end
		if (inv_reg) begin
			for (int i = 0; i < n; i++) begin
				slot_re[i] = p_mul(slot_re[i], res_t'(1) << (61 - lg));
				slot_im[i] = p_mul(slot_im[i], res_t'(1) << (61 - lg));
			end
		end
	endfunction

	task automatic report(input string what, input res_t got, input res_t want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int              lg;
		spectrum_point_t e;
		if (!arst_n) begin
			fill_cnt = '0;
			lg_reg = 3'd6;
			inv_reg = 1'b0;
			spectrum_q.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (spectrum_q.size() == 0) begin
					$display("unexpected output transfer: %0d %0d", out_real, out_imag);
					fail_count++;
				end else begin
					e = spectrum_q.pop_front();
					if (out_real !== e.re) report("out_real", out_real, e.re);
					if (out_imag !== e.im) report("out_imag", out_imag, e.im);
					if (last_out !== e.last) begin
						report("last_out", res_t'(last_out), res_t'(e.last));
					end
				end
			end
			if (in_valid && in_ready) begin
				lg = (lg_reg == 0) ? 1 : (lg_reg > 6) ? 6 : lg_reg;
				// an all-ones residue reads as zero
				slot_re[fill_cnt[5:0]] = (elem_real == MP) ? '0 : elem_real;
				slot_im[fill_cnt[5:0]] = (elem_imag == MP) ? '0 : elem_imag;
				fill_cnt = fill_cnt + 7'd1;
				if (fill_cnt >= (7'd1 << lg)) begin
					transform_slots(lg);
					for (int i = 0; i < (1 << lg); i++) begin
						e.re = slot_re[i];
						e.im = slot_im[i];
						e.last = (i == (1 << lg) - 1);
						spectrum_q.push_back(e);
					end
					fill_cnt = '0;
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_LOG_SIZE) lg_reg = cfg_data;
				else inv_reg = cfg_data[0];
			end
		end
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	import cmt_pkg::*;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic            cfg_index;
	logic [LG_W-1:0] cfg_data;
	logic            in_valid;
	logic            in_ready;
	res_t            elem_real;
	res_t            elem_imag;
	logic            out_valid;
	logic            out_ready;
	res_t            out_real;
	res_t            out_imag;
	logic            last_out;
	int              fail_count;
	int              pending;
	int              results_seen;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              elems_sent;
	int              blocks_run;

	complex_mersenne_transform dut (.*);

	cmt_tb_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#50_000_000;
		$display("timeout");
		$display("Test completed with failures");
		$finish;
	end

	function automatic res_t rand_res();
		case ($urandom_range(9))
			0: return '0;
			1: return MP - 61'd1;
			2: return MP;
			default: return res_t'({$urandom, $urandom});
		endcase
	endfunction

	// returns at the edge of the transfer with valid still high
	task automatic send_elem(input res_t re, input res_t im);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		elem_real <= re;
		elem_imag <= im;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		elems_sent++;
	endtask

	// called at a clock edge: stop sending and let every result drain
	task automatic drain();
		in_valid <= 1'b0;
		// let the checker see the last transfer before looking at its queue
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [LG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_block(input logic [LG_W-1:0] lg, input logic inv);
		int n;
		drain();
		cfg_write(REG_LOG_SIZE, lg);
		cfg_write(REG_INVERSE, {2'b0, inv});
		n = 1 << ((lg == 0) ? 1 : (lg > 6) ? 6 : lg);
		for (int i = 0; i < n; i++) send_elem(rand_res(), rand_res());
		blocks_run++;
	endtask

	initial begin
		int lg_pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LOG_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		elem_real = '0;
		elem_imag = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		elems_sent = 0;
		blocks_run = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest length, field extremes, all-ones residue
		cfg_write(REG_LOG_SIZE, 3'd1);
		cfg_write(REG_INVERSE, 3'd0);
		send_elem('0, '0);
		send_elem(MP - 61'd1, MP - 61'd1);
		send_elem(MP, MP);
		send_elem(61'd1, MP - 61'd1);
		// zero length reads as two points
		drain();
		cfg_write(REG_LOG_SIZE, 3'd0);
		send_elem(MP - 61'd1, 61'd1);
		send_elem(61'd1, MP);
		// inverse at four points
		drain();
		cfg_write(REG_LOG_SIZE, 3'd2);
		cfg_write(REG_INVERSE, 3'd1);
		for (int i = 0; i < 4; i++) send_elem(MP - 61'd1, res_t'(i));
		// length lowered below the fill count mid-load
		drain();
		cfg_write(REG_LOG_SIZE, 3'd3);
		cfg_write(REG_INVERSE, 3'd0);
		for (int i = 0; i < 5; i++) send_elem(rand_res(), rand_res());
		drain();
		cfg_write(REG_LOG_SIZE, 3'd2);
		send_elem(rand_res(), rand_res());

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			send_idle_pct = (phase == 1) ? 78 : (phase == 3) ? 10 : 0;
			recv_stall_pct = (phase == 2) ? 78 : (phase == 3) ? 10 : 0;
			if (phase == 0) run_block(3'd7, 1'b1);
			if (phase == 2) run_block(3'd6, 1'b0);
			while (elems_sent < 90 * (phase + 1)) begin
				lg_pick = $urandom_range(15);
				case (lg_pick)
					0: run_block(3'd0, 1'($urandom_range(1)));
					1: run_block(3'd5, 1'($urandom_range(1)));
					2: run_block(3'd4, 1'($urandom_range(1)));
					default: run_block(3'($urandom_range(3, 1)), 1'($urandom_range(1)));
				endcase
			end
		end

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d elements in %0d transform blocks, %0d results compared",
			elems_sent, blocks_run, results_seen);
		$display("lengths 2 to 64 forward and inverse, with sender and receiver stalls");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
